/* rtl/kpd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad entry package
// Shared constants, item types and helpers for the keypad scanner with
// two-digit threshold entry.
// ----------------------------------------------------------------------------
package kpd_pkg;

	localparam int ROWS           = 4;
	localparam int COLUMNS        = 3;
	localparam int NUM_KEYS       = ROWS * COLUMNS;
	localparam int KEY_W          = $clog2(NUM_KEYS);
	localparam int LAST_DIGIT_KEY = 8;
	localparam int KEY_STAR       = 9;
	localparam int KEY_ZERO       = 10;
	localparam int KEY_HASH       = 11;
	localparam int DIGIT_W        = 4;
	localparam int THR_W          = 7;
	localparam int THR_RESET      = 30;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

	typedef enum logic {
		FUNC_SCAN = 1'b0,
		FUNC_TICK = 1'b1
	} func_t;

	typedef struct packed {
		func_t               func;
		logic [NUM_KEYS-1:0] scan_bits;
		logic                column_any;
	} key_item_t;

	typedef struct packed {
		logic             key_seen;
		logic [KEY_W-1:0] key_index;
		logic [THR_W-1:0] threshold_value;
		logic             threshold_loaded;
		logic             digit_pending;
		logic             key_held;
	} res_item_t;

	// Summary of one transaction as seen by the back end
	typedef struct packed {
		func_t              func;
		logic               column_any;
		logic               any_key;
		logic [KEY_W-1:0]   last_key;
		logic               star;
		logic               zero;
		logic               hash;
		logic [1:0]         dig_cnt;
		logic               dig_odd;
		logic [DIGIT_W-1:0] d1;
		logic [DIGIT_W-1:0] d2;
		logic [DIGIT_W-1:0] d3;
	} cls_t;

	function automatic logic [THR_W-1:0] mul10(input logic [DIGIT_W-1:0] d);
		logic [THR_W-1:0] x;
		x = THR_W'(d);
		return (x << 3) + (x << 1);
	endfunction

	function automatic logic [THR_W-1:0] join_digits(input logic [DIGIT_W-1:0] hi,
	                                                  input logic [DIGIT_W-1:0] lo);
		return mul10(hi) + THR_W'(lo);
	endfunction

endpackage

/* rtl/kpd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad front end
// Classifies a scan transaction: pressed digit keys among the digit rows,
// the last three of them, and the special keys.
// ----------------------------------------------------------------------------
module kpd_front (
	input  kpd_pkg::key_item_t item,
	output kpd_pkg::cls_t      cls
);
	import kpd_pkg::*;

	always_comb begin
		cls            = '0;
		cls.func       = item.func;
		cls.column_any = item.column_any;
		cls.any_key    = |item.scan_bits;
		cls.star       = item.scan_bits[KEY_STAR];
		cls.zero       = item.scan_bits[KEY_ZERO];
		cls.hash       = item.scan_bits[KEY_HASH];
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (item.scan_bits[i]) begin
				cls.last_key = KEY_W'(i);
			end
		end
		for (int i = 0; i <= LAST_DIGIT_KEY; i++) begin
			if (item.scan_bits[i]) begin
				cls.d3      = cls.d2;
				cls.d2      = cls.d1;
				cls.d1      = DIGIT_W'(i + 1);
				cls.dig_odd = ~cls.dig_odd;
				if (cls.dig_cnt != 2'd3) begin
					cls.dig_cnt = cls.dig_cnt + 2'd1;
				end
			end
		end
	end

endmodule

/* rtl/kpd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad transaction queue
// Short queue between front end and back end.
// ----------------------------------------------------------------------------
module kpd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kpd_pkg::cls_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output kpd_pkg::cls_t rdata
);
	import kpd_pkg::*;

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

/* rtl/kpd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad back end
// Applies classified transactions to the entry state and registers results.
// ----------------------------------------------------------------------------
module kpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_nonempty,
	input  kpd_pkg::cls_t       q_data,
	output logic                q_pop,
	output logic                res_valid,
	input  logic                res_stall,
	output kpd_pkg::res_item_t  res_item
);
	import kpd_pkg::*;

	logic               released_q;
	logic [DIGIT_W-1:0] first_q;
	logic               count_q;
	logic [THR_W-1:0]   thr_q;
	logic               valid_q;
	res_item_t          item_q;

	logic               released_d;
	logic [DIGIT_W-1:0] first_d;
	logic               count_d;
	logic [THR_W-1:0]   thr_d;
	logic               loaded_d;
	logic               apply;
	logic               len_zero;
	logic               len_one;
	logic               len_odd;
	logic [DIGIT_W-1:0] prev;
	logic [DIGIT_W-1:0] prev2;
	res_item_t          item_d;

	assign q_pop     = q_nonempty && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign res_item  = item_q;

	assign apply    = (q_data.func == FUNC_SCAN) && released_q && q_data.any_key;
	assign len_zero = !count_q && (q_data.dig_cnt == 2'd0);
	assign len_one  = (!count_q && (q_data.dig_cnt == 2'd1))
	               || (count_q && (q_data.dig_cnt == 2'd0));
	assign len_odd  = count_q ^ q_data.dig_odd;
	assign prev     = (q_data.dig_cnt[1]) ? q_data.d2 : first_q;
	assign prev2    = (q_data.dig_cnt == 2'd3) ? q_data.d3 : first_q;

	always_comb begin
		released_d = released_q;
		first_d    = first_q;
		count_d    = count_q;
		thr_d      = thr_q;
		loaded_d   = 1'b0;
		if (apply) begin
			released_d = 1'b0;
			priority if (len_zero) begin
				first_d = first_q;
			end else if (len_one) begin
				count_d = 1'b1;
				first_d = count_q ? first_q : q_data.d1;
			end else if (len_odd) begin
				thr_d    = join_digits(prev2, prev);
				loaded_d = 1'b1;
				count_d  = 1'b1;
				first_d  = q_data.d1;
			end else begin
				thr_d    = join_digits(prev, q_data.d1);
				loaded_d = 1'b1;
				count_d  = 1'b0;
				first_d  = '0;
			end
			if (q_data.star) begin
				count_d = 1'b0;
				first_d = '0;
			end
			if (q_data.zero) begin
				if (count_d) begin
					thr_d    = join_digits(first_d, '0);
					loaded_d = 1'b1;
					count_d  = 1'b0;
				end else begin
					count_d = 1'b1;
				end
				first_d = '0;
			end
			if (q_data.hash) begin
				count_d = 1'b0;
				first_d = '0;
			end
		end else if (q_data.func == FUNC_TICK && !released_q && !q_data.column_any) begin
			released_d = 1'b1;
		end
	end

	always_comb begin
		item_d                  = '0;
		item_d.key_seen         = apply;
		item_d.key_index        = apply ? q_data.last_key : '0;
		item_d.threshold_value  = thr_d;
		item_d.threshold_loaded = loaded_d;
		item_d.digit_pending    = count_d;
		item_d.key_held         = !released_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			released_q <= 1'b1;
			first_q    <= '0;
			count_q    <= 1'b0;
			thr_q      <= THR_W'(THR_RESET);
			valid_q    <= 1'b0;
		end else begin
			if (q_pop) begin
				released_q <= released_d;
				first_q    <= first_d;
				count_q    <= count_d;
				thr_q      <= thr_d;
			end
			if (q_pop) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= item_d;
		end
	end

endmodule

/* rtl/keypad_scan_two_digit_entry_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner with two-digit threshold entry
// Takes scan transactions and release-check ticks; returns one result per
// transaction with the accepted key and the current threshold.
//
// Input channel key_valid / key_stall / key_item: one transaction per
// cycle while key_stall is low. func selects a scan (scan_bits used) or
// a release-check tick (column_any used). Output channel res_valid /
// res_stall / res_item: one result per transaction, in order.
// An accepted transaction is written into the queue and then, when the
// back end pops it, into the output register that drives res_item.
// The back end pops one transaction per cycle while res_stall is low or
// its output register is empty; the front end is combinational and
// classifies the transaction in the same cycle it is accepted.
// A two-entry queue sits between front and back end. While the receiver
// stalls, the output register holds its result and the queue fills;
// key_stall rises once the queue is full.
// Reset: the keypad counts as released, no digit is pending and the
// threshold is 30.
// ----------------------------------------------------------------------------
module keypad_scan_two_digit_entry_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_valid,
	output logic               key_stall,
	input  kpd_pkg::key_item_t key_item,
	output logic               res_valid,
	input  logic               res_stall,
	output kpd_pkg::res_item_t res_item
);
	import kpd_pkg::*;

	cls_t cls;
	cls_t q_data;
	logic q_full;
	logic q_nonempty;
	logic q_pop;

	assign key_stall = q_full;

	kpd_front u_front (
		.item (key_item),
		.cls  (cls)
	);

	kpd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (key_valid && !q_full),
		.wdata    (cls),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_data)
	);

	kpd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item)
	);

endmodule

/* bench/keypad_scan_two_digit_entry_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scanner with two-digit threshold entry: testbench
// Drives scan transactions and release-check ticks into the block and
// predicts each result from a private model of the lockout, the partial
// entry and the threshold. Results are compared field by field in order.
// A directed opening covers lockout, release, star and hash discards,
// multi-key scans and the threshold extremes 0 and 99. Then comes a long
// blocked receiver that fills the block, followed by random press/release
// sequences mixed with noise. Both sides idle in random bursts, except
// near the end of the run.
// ----------------------------------------------------------------------------
module keypad_scan_two_digit_entry_top_tb;
	import kpd_pkg::*;

	localparam int HOLD_CYCLES  = 100;
	localparam int RANDOM_ITEMS = 894;
	localparam int QUIET_ITEMS  = 150;
	localparam int PRESS_ITEMS  = 30;

	class entry_scoreboard;
		bit               released = 1'b1;
		logic [DIGIT_W-1:0] first_digit = '0;
		bit               digit_held = 1'b0;
		logic [THR_W-1:0] threshold = THR_W'(THR_RESET);
		res_item_t        pending_results[$];
		int               key_count = 0;
		int               dropped_scans = 0;
		int               load_count = 0;
		int               discard_count = 0;
		int               checked_count = 0;
		int               error_count = 0;

		function int scored_items();
			return key_count - dropped_scans;
		endfunction

		function res_item_t predict_entry(key_item_t it);
			res_item_t          r;
			logic [DIGIT_W-1:0] d;
			bit                 is_digit;
			r = '0;
			if (it.func == FUNC_SCAN) begin
				if (!released)
					dropped_scans++;
				else for (int k = 0; k < NUM_KEYS; k++) begin
					if (it.scan_bits[k]) begin
						r.key_seen  = 1'b1;
						r.key_index = KEY_W'(k);
						is_digit    = 1'b1;
						if (k <= LAST_DIGIT_KEY)
							d = DIGIT_W'(k + 1);
						else if (k == KEY_ZERO)
							d = '0;
						else
							is_digit = 1'b0;
						if (!is_digit) begin
							digit_held  = 1'b0;
							first_digit = '0;
							discard_count++;
						end else if (!digit_held) begin
							first_digit = d;
							digit_held  = 1'b1;
						end else begin
							threshold = THR_W'(first_digit) * THR_W'(10) + THR_W'(d);
							r.threshold_loaded = 1'b1;
							digit_held  = 1'b0;
							first_digit = '0;
							load_count++;
						end
						released = 1'b0;
					end
				end
			end else if (!released && !it.column_any) begin
				released = 1'b1;
			end
			r.threshold_value = threshold;
			r.digit_pending   = digit_held;
			r.key_held        = !released;
			return r;
		endfunction

		function void note_key(key_item_t it);
			key_count++;
			pending_results.push_back(predict_entry(it));
		endfunction

		function void report(string what, res_item_t want, res_item_t got);
			error_count++;
			if (error_count <= 10) begin
				$write("%t %s: expected seen=%0d idx=%0d thr=%0d load=%0d pend=%0d held=%0d",
					$realtime, what, want.key_seen, want.key_index, want.threshold_value,
					want.threshold_loaded, want.digit_pending, want.key_held);
				$display(", got seen=%0d idx=%0d thr=%0d load=%0d pend=%0d held=%0d",
					got.key_seen, got.key_index, got.threshold_value,
					got.threshold_loaded, got.digit_pending, got.key_held);
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			checked_count++;
			if (pending_results.size() == 0) begin
				report("unexpected result", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.key_seen !== want.key_seen || got.key_index !== want.key_index ||
				    got.threshold_value !== want.threshold_value ||
				    got.threshold_loaded !== want.threshold_loaded ||
				    got.digit_pending !== want.digit_pending ||
				    got.key_held !== want.key_held)
					report("result mismatch", want, got);
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      key_valid;
	logic      key_stall;
	key_item_t key_item;
	logic      res_valid;
	logic      res_stall;
	res_item_t res_item;

	entry_scoreboard sb;
	bit              sender_idle = 1'b1;
	bit              quiet = 1'b0;
	bit              hold_req = 1'b0;
	bit              hold_active = 1'b0;

	keypad_scan_two_digit_entry_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key_item  (key_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && key_valid && !key_stall)
			sb.note_key(key_item);
		if (arst_n && res_valid && !res_stall)
			sb.check_result(res_item);
	end

	// receiver: random stall bursts, one long hold on request
	initial begin
		bit stall_bit;
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_active = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				res_stall <= 1'b0;
				hold_req    = 1'b0;
				hold_active = 1'b0;
			end else begin
				stall_bit = quiet ? 1'b0 : 1'($urandom_range(0, 2) == 0);
				n = quiet ? 1 : $urandom_range(1, 16);
				res_stall <= stall_bit;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	task automatic send_item(input key_item_t it);
		int gap;
		if (sender_idle && !quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			key_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		key_item  <= it;
		key_valid <= 1'b1;
		@(posedge clk);
		while (key_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_scan(input logic [NUM_KEYS-1:0] bits);
		key_item_t it;
		it.func       = FUNC_SCAN;
		it.scan_bits  = bits;
		it.column_any = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_tick(input logic col);
		key_item_t it;
		it.func       = FUNC_TICK;
		it.scan_bits  = NUM_KEYS'($urandom);
		it.column_any = col;
		send_item(it);
	endtask

	function automatic int pick_key();
		int r;
		if ($urandom_range(0, 9) < 8) begin
			r = $urandom_range(0, 9);
			return (r == 9) ? KEY_ZERO : r;
		end
		return $urandom_range(0, 1) ? KEY_STAR : KEY_HASH;
	endfunction

	task automatic run_directed();
		send_tick(1'b1);
		send_scan('0);
		send_scan(NUM_KEYS'(1) << 0);
		send_scan(NUM_KEYS'(1) << 5);
		send_tick(1'b1);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << KEY_ZERO);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << LAST_DIGIT_KEY);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << LAST_DIGIT_KEY);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << KEY_ZERO);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << KEY_ZERO);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << 0);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << KEY_STAR);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << 3);
		send_tick(1'b0);
		send_scan(NUM_KEYS'(1) << KEY_HASH);
		send_tick(1'b0);
		send_scan('1);
		send_tick(1'b0);
	endtask

	task automatic run_random();
		key_item_t            it;
		logic [NUM_KEYS-1:0] bits;
		int                   goal;
		goal = sb.key_count + RANDOM_ITEMS;
		while (sb.key_count < goal) begin
			quiet = (goal - sb.key_count) < QUIET_ITEMS;
			if ($urandom_range(0, 31) == 0)
				sender_idle = !sender_idle;
			if ($urandom_range(0, 9) < 7) begin
				bits = NUM_KEYS'(1) << pick_key();
				if ($urandom_range(0, 9) == 0)
					bits |= NUM_KEYS'(1) << pick_key();
				send_scan(bits);
				if ($urandom_range(0, 3) == 0)
					send_scan(NUM_KEYS'($urandom));
				if ($urandom_range(0, 2) == 0)
					send_tick(1'b1);
				send_tick(1'b0);
			end else begin
				it.func       = func_t'($urandom_range(0, 1));
				it.scan_bits  = NUM_KEYS'($urandom);
				it.column_any = 1'($urandom);
				send_item(it);
			end
		end
	endtask

	initial begin
		sb = new;
		arst_n    = 1'b0;
		key_valid = 1'b0;
		key_item  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		// fill the block against a blocked receiver
		key_valid <= 1'b0;
		hold_req = 1'b1;
		wait (hold_active);
		@(negedge clk);
		sender_idle = 1'b0;
		for (int i = 0; i < PRESS_ITEMS; i++) begin
			if (i % 3 == 0)
				send_scan(NUM_KEYS'(1) << pick_key());
			else
				send_tick(1'($urandom));
		end
		sender_idle = 1'b1;

		run_random();
		key_valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d transactions: %0d scans dropped under lockout, %0d loads,",
			sb.key_count, sb.dropped_scans, sb.load_count);
		$display("%0d entries discarded by star or hash; checked %0d results, %0d failures.",
			sb.discard_count, sb.checked_count, sb.error_count);
		if (sb.error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
